[hw/rtl/dotq_pkg.sv]
// Shared types and codes for the deadline-ordered timer queue.
`timescale 1ns / 1ps

package dotq_pkg;

  localparam int FireLimit = 16;
  localparam int FireW     = $clog2(FireLimit + 1);

  localparam logic OpInsert = 1'b0;
  localparam logic OpTick   = 1'b1;

  localparam logic [1:0] KindAccepted = 2'd0;
  localparam logic [1:0] KindFull     = 2'd1;
  localparam logic [1:0] KindFired    = 2'd2;
  localparam logic [1:0] KindNone     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS,
    ST_FIRE
  } dotq_state_e;

endpackage

[hw/rtl/dotq_ram.sv]
// Single-port-write, registered-read entry store for the timer queue.
`timescale 1ns / 1ps

module dotq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 80
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/deadline_ordered_timer_queue.sv]
// Insert: an empty queue writes the head slot and a full queue is refused from idle;
// else it scans, shifts each later entry up by a read and a write, then inserts, all
// through one 64-bit comparator and one RAM port. Tick: one RAM read per fired timer.
// Throughput: one item at a time, taken only when idle with the output register free.
// Reset: asynchronous, active low; clears count, ring head, sequencer and output valid.
// Entry RAM contents are not cleared; only entries below the count are ever used.
`timescale 1ns / 1ps

module deadline_ordered_timer_queue #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [63:0] deadline_i,
  input  logic [15:0] timer_tag_i,
  input  logic [63:0] now_time_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] fired_tag_o,
  output logic [63:0] fired_deadline_o,
  output logic        last_o
);

  import dotq_pkg::*;

  // Stored tag width: the tag port is 16 bits, TAG_BITS may mask it further.
  localparam int TagW  = (TAG_BITS < 16) ? TAG_BITS : 16;
  localparam int IdxW  = $clog2(DEPTH);
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int SumW  = $clog2(2 * DEPTH);
  localparam int DataW = 64 + TagW;

  // The queue is a ring in RAM: logical entry l lives at (head + l) mod DEPTH.
  // Popping advances the head; inserting shifts the tail up by one.
  function automatic logic [IdxW-1:0] phys(input logic [IdxW-1:0] head,
                                           input logic [CntW-1:0] l);
    logic [SumW-1:0] s;
    s = SumW'(head) + SumW'(l);
    if (s >= SumW'(DEPTH)) begin
      s = s - SumW'(DEPTH);
    end
    return s[IdxW-1:0];
  endfunction

  dotq_state_e state_q, state_d;

  logic            op_q, op_d;
  logic [63:0]     key_q, key_d;       // deadline for an insert, now for a tick
  logic [TagW-1:0] tag_q, tag_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;       // scan position, then shift source
  logic [CntW-1:0] pos_q, pos_d;       // insert position
  logic [FireW-1:0] fired_q, fired_d;

  // Fired entry held back until the next compare tells whether it is the last.
  logic            pend_q, pend_d;
  logic [63:0]     pend_dl_q, pend_dl_d;
  logic [TagW-1:0] pend_tag_q, pend_tag_d;

  // Output register
  logic            out_valid_q, out_valid_d;
  logic [1:0]      kind_q, kind_d;
  logic [15:0]     otag_q, otag_d;
  logic [63:0]     odl_q, odl_d;
  logic            last_q, last_d;

  // RAM port
  logic             we;
  logic [IdxW-1:0]  waddr;
  logic [DataW-1:0] wdata;
  logic             re;
  logic [IdxW-1:0]  raddr;
  logic [DataW-1:0] rdata;
  logic [63:0]      rd_dl;
  logic [TagW-1:0]  rd_tag;

  logic        out_free;
  logic        accept;
  logic [63:0] cmp_a;
  logic [63:0] cmp_b;
  logic        cmp_le;
  logic        due;

  dotq_ram #(
    .DEPTH(DEPTH),
    .WIDTH(DataW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_dl  = rdata[63:0];
  assign rd_tag = rdata[DataW-1:64];

  // One shared comparator: insert asks key <= entry, tick asks entry <= now.
  assign cmp_a  = (op_q == OpTick) ? rd_dl : key_q;
  assign cmp_b  = (op_q == OpTick) ? key_q : rd_dl;
  assign cmp_le = (cmp_a <= cmp_b);
  assign due    = (count_q != '0) && (fired_q < FireW'(FireLimit)) && cmp_le;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    tag_d       = tag_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    fired_d     = fired_q;
    pend_d      = pend_q;
    pend_dl_d   = pend_dl_q;
    pend_tag_d  = pend_tag_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    otag_d      = otag_q;
    odl_d       = odl_q;
    last_d      = last_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    re          = 1'b0;
    raddr       = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d  = op_i;
          key_d = (op_i == OpTick) ? now_time_i : deadline_i;
          tag_d = timer_tag_i[TagW-1:0];
          if (op_i == OpInsert) begin
            if (count_q == CntW'(DEPTH)) begin
              out_valid_d = 1'b1;
              kind_d      = KindFull;
              otag_d      = '0;
              odl_d       = '0;
              last_d      = 1'b1;
            end else if (count_q == '0) begin
              // Empty queue: write straight to the head slot.
              we          = 1'b1;
              waddr       = head_q;
              wdata       = {timer_tag_i[TagW-1:0], deadline_i};
              count_d     = count_q + CntW'(1);
              out_valid_d = 1'b1;
              kind_d      = KindAccepted;
              otag_d      = '0;
              odl_d       = '0;
              last_d      = 1'b1;
            end else begin
              re      = 1'b1;
              raddr   = phys(head_q, '0);
              idx_d   = '0;
              state_d = ST_SCAN;
            end
          end else begin
            if (count_q == '0) begin
              out_valid_d = 1'b1;
              kind_d      = KindNone;
              otag_d      = '0;
              odl_d       = '0;
              last_d      = 1'b1;
            end else begin
              re      = 1'b1;
              raddr   = phys(head_q, '0);
              fired_d = '0;
              pend_d  = 1'b0;
              state_d = ST_FIRE;
            end
          end
        end
      end

      ST_SCAN: begin
        // Stop at the first entry whose deadline is greater or equal.
        if (cmp_le) begin
          pos_d   = idx_q;
          idx_d   = count_q - CntW'(1);
          state_d = ST_SH_RD;
        end else if (idx_q + CntW'(1) == count_q) begin
          pos_d   = count_q;
          state_d = ST_INS;
        end else begin
          idx_d = idx_q + CntW'(1);
          re    = 1'b1;
          raddr = phys(head_q, idx_q + CntW'(1));
        end
      end

      ST_SH_RD: begin
        re      = 1'b1;
        raddr   = phys(head_q, idx_q);
        state_d = ST_SH_WR;
      end

      ST_SH_WR: begin
        // Move one entry up a slot, walking from the tail down to the insert point.
        we    = 1'b1;
        waddr = phys(head_q, idx_q + CntW'(1));
        wdata = rdata;
        if (idx_q == pos_q) begin
          state_d = ST_INS;
        end else begin
          idx_d   = idx_q - CntW'(1);
          state_d = ST_SH_RD;
        end
      end

      ST_INS: begin
        if (out_free) begin
          we          = 1'b1;
          waddr       = phys(head_q, pos_q);
          wdata       = {tag_q, key_q};
          count_d     = count_q + CntW'(1);
          out_valid_d = 1'b1;
          kind_d      = KindAccepted;
          otag_d      = '0;
          odl_d       = '0;
          last_d      = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_FIRE: begin
        if (out_free) begin
          if (due) begin
            if (pend_q) begin
              out_valid_d = 1'b1;
              kind_d      = KindFired;
              otag_d      = 16'(pend_tag_q);
              odl_d       = pend_dl_q;
              last_d      = 1'b0;
            end
            // Pop the head and fetch the next one.
            pend_d     = 1'b1;
            pend_dl_d  = rd_dl;
            pend_tag_d = rd_tag;
            head_d     = phys(head_q, CntW'(1));
            count_d    = count_q - CntW'(1);
            fired_d    = fired_q + FireW'(1);
            re         = 1'b1;
            raddr      = phys(head_q, CntW'(1));
          end else begin
            out_valid_d = 1'b1;
            last_d      = 1'b1;
            if (pend_q) begin
              kind_d = KindFired;
              otag_d = 16'(pend_tag_q);
              odl_d  = pend_dl_q;
            end else begin
              kind_d = KindNone;
              otag_d = '0;
              odl_d  = '0;
            end
            pend_d  = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    tag_q      <= tag_d;
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    fired_q    <= fired_d;
    pend_dl_q  <= pend_dl_d;
    pend_tag_q <= pend_tag_d;
    kind_q     <= kind_d;
    otag_q     <= otag_d;
    odl_q      <= odl_d;
    last_q     <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign fired_tag_o      = otag_q;
  assign fired_deadline_o = odl_q;
  assign last_o           = last_q;

endmodule

[tb/sv/tb_deadline_ordered_timer_queue.sv]
// Self-checking testbench for the deadline-ordered timer queue.
`timescale 1ns / 1ps

module tb_deadline_ordered_timer_queue;
  import dotq_pkg::*;

  localparam int QDepth = 16;
  localparam int TagBits = 16;
  localparam logic [15:0] TagMask = 16'((32'd1 << TagBits) - 1);
  localparam logic [63:0] MaxTime = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int RandomItems = 430;
  // Worst case per item: a full scan and shift, sixteen results each held off by the
  // longest receiver stall, plus a sender gap; taken several times over.
  localparam int CycleLimit = 1_000_000;
  localparam int DrainCycles = 64;

  typedef struct packed {
    logic [63:0] deadline;
    logic [15:0] tag;
  } timer_entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] tag;
    logic [63:0] deadline;
    logic        last;
  } timer_result_t;

  // Shadow of the queue plus the results it has promised, oldest first.
  class expiry_scoreboard;
    timer_entry_t  pending_timers[$];
    timer_result_t due_results[$];
    int errors;
    int n_insert, n_tick, n_fired, n_full, n_none, n_checked;

    function new();
      errors = 0;
      n_insert = 0;
      n_tick = 0;
      n_fired = 0;
      n_full = 0;
      n_none = 0;
      n_checked = 0;
    endfunction

    task report(input string msg);
      $display("%0t ns  mismatch: %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return due_results.size();
    endfunction

    // Update the shadow queue for one accepted transfer and queue its results.
    function void note_transfer(input logic op, input logic [63:0] deadline,
                                input logic [15:0] tag, input logic [63:0] now_time);
      timer_entry_t  ent;
      timer_result_t res;
      int pos;
      int fired;
      res = '0;
      if (op == OpInsert) begin
        n_insert++;
        if (pending_timers.size() >= QDepth) begin
          n_full++;
          res.kind = KindFull;
          res.last = 1'b1;
          due_results.push_back(res);
        end else begin
          pos = pending_timers.size();
          for (int i = 0; i < pending_timers.size(); i++) begin
            if (deadline <= pending_timers[i].deadline) begin
              pos = i;
              break;
            end
          end
          ent.deadline = deadline;
          ent.tag = tag & TagMask;
          pending_timers.insert(pos, ent);
          res.kind = KindAccepted;
          res.last = 1'b1;
          due_results.push_back(res);
        end
      end else begin
        n_tick++;
        fired = 0;
        while (pending_timers.size() > 0 && fired < FireLimit &&
               pending_timers[0].deadline <= now_time) begin
          ent = pending_timers.pop_front();
          res.kind = KindFired;
          res.tag = ent.tag;
          res.deadline = ent.deadline;
          res.last = 1'b0;
          due_results.push_back(res);
          fired++;
        end
        n_fired += fired;
        if (fired == 0) begin
          n_none++;
          res = '0;
          res.kind = KindNone;
          res.last = 1'b1;
          due_results.push_back(res);
        end else begin
          due_results[due_results.size() - 1].last = 1'b1;
        end
      end
    endfunction

    task check_result(input logic [1:0] kind, input logic [15:0] tag,
                      input logic [63:0] deadline, input logic last);
      timer_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result kind=%0d tag=%h", kind, tag));
      end else begin
        want = due_results.pop_front();
        n_checked++;
        if (kind !== want.kind)
          report($sformatf("kind %0d, want %0d", kind, want.kind));
        if (tag !== want.tag)
          report($sformatf("fired_tag %h, want %h", tag, want.tag));
        if (deadline !== want.deadline)
          report($sformatf("fired_deadline %h, want %h", deadline, want.deadline));
        if (last !== want.last)
          report($sformatf("last %0b, want %0b", last, want.last));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        op_i;
  logic [63:0] deadline_i;
  logic [15:0] timer_tag_i;
  logic [63:0] now_time_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [15:0] fired_tag_o;
  logic [63:0] fired_deadline_o;
  logic        last_o;

  expiry_scoreboard board;
  int unsigned cycle_count;

  // sender pacing
  int burst_left;
  // receiver stall pattern
  int stall_mode;
  int mode_left;
  int stall_hold;

  // random stimulus shaping
  logic [63:0] time_base;
  logic [63:0] prev_deadline;
  int insert_pct;

  deadline_ordered_timer_queue #(
    .DEPTH   (QDepth),
    .TAG_BITS(TagBits)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .deadline_i      (deadline_i),
    .timer_tag_i     (timer_tag_i),
    .now_time_i      (now_time_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .fired_tag_o     (fired_tag_o),
    .fired_deadline_o(fired_deadline_o),
    .last_o          (last_o)
  );

  initial clk_i = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Guard against a hung block: give up well past the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, board.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result monitor: a transfer happens when valid is high and stall is low at the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(kind_o, fired_tag_o, fired_deadline_o, last_o);
  end

  // Receiver stall pattern: switch between modes every so often so that
  // stalls land on every phase of the result stream, including stall-free runs.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode <= 0;
      mode_left <= 200;
      stall_hold <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(64, 256);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: begin
          out_stall_i <= 1'b0;
        end
        1: begin
          out_stall_i <= ($urandom_range(0, 1) == 1);
        end
        2: begin
          // long stalls with short release windows
          if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            out_stall_i <= 1'b1;
          end else if ($urandom_range(0, 3) == 0) begin
            stall_hold <= $urandom_range(1, 20);
            out_stall_i <= 1'b1;
          end else begin
            out_stall_i <= 1'b0;
          end
        end
        default: begin
          out_stall_i <= cycle_count[0];
        end
      endcase
    end
  end

  // Present one item and hold it until the block takes the transfer.
  task automatic send_item(input logic op, input logic [63:0] deadline,
                           input logic [15:0] tag, input logic [63:0] now_time);
    in_valid_i <= 1'b1;
    op_i <= op;
    deadline_i <= deadline;
    timer_tag_i <= tag;
    now_time_i <= now_time;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_transfer(op, deadline, tag, now_time);
  endtask

  // Close a burst with a random gap, or keep valid high into the next item.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Drop valid and hold off until every expected result has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic insert_timer(input logic [63:0] deadline, input logic [15:0] tag);
    send_item(OpInsert, deadline, tag, rand64());
    pace_sender();
  endtask

  task automatic tick_at(input logic [63:0] now_time);
    send_item(OpTick, rand64(), 16'($urandom), now_time);
    pace_sender();
  endtask

  // One random item: mostly a plausible timer workload around a running clock,
  // with some fully random transfers and an occasional flush at the top of time.
  task automatic random_item();
    int pick;
    logic [63:0] dl;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_item(1'($urandom), rand64(), 16'($urandom), rand64());
      pace_sender();
    end else if ($urandom_range(0, 99) < insert_pct) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) dl = rand64();
      else if (pick < 16) dl = prev_deadline;
      else if (pick < 20) dl = MaxTime;
      else dl = time_base + 64'($urandom_range(0, 200));
      prev_deadline = dl;
      insert_timer(dl, 16'($urandom));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        tick_at(MaxTime);
      end else if (pick < 8) begin
        tick_at(rand64());
      end else begin
        time_base = time_base + 64'($urandom_range(0, 150));
        tick_at(time_base);
      end
    end
  endtask

  initial begin
    board = new();
    cycle_count <= 0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    op_i <= OpInsert;
    deadline_i <= '0;
    timer_tag_i <= '0;
    now_time_i <= '0;
    burst_left = 0;
    time_base = '0;
    prev_deadline = '0;
    insert_pct = 60;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: tick on an empty queue, extremes of deadline and tag.
    tick_at('0);
    insert_timer('0, 16'h0000);
    insert_timer(MaxTime, 16'hFFFF);
    insert_timer(64'd5, 16'h0001);
    // equal deadlines: the newer timer must fire first
    insert_timer(64'd5, 16'h0002);
    tick_at(64'd4);
    tick_at(64'd5);
    // a deadline at the maximum fires only once time reaches it
    tick_at(MaxTime - 64'd1);
    tick_at(MaxTime);

    // Fill the queue, overflow it, then expire every entry in one tick.
    for (int i = 0; i < QDepth; i++)
      insert_timer(64'(i / 3) * 64'd1000 + 64'(i % 2), 16'(16'hA500 + i));
    insert_timer(64'd1, 16'h5A5A);
    tick_at(MaxTime);
    wait_for_drain();

    // Random part: phases with different insert/tick mixes so the queue
    // spends time both near empty and pinned at full.
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 50;
          1: insert_pct = 75;
          default: insert_pct = 90;
        endcase
      end
      if (n % 110 == 109) wait_for_drain();
      random_item();
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));

    $display("covered %0d inserts (%0d rejected as full) and %0d ticks",
             board.n_insert, board.n_full, board.n_tick);
    $display("%0d timers fired, %0d ticks with nothing due, %0d results checked",
             board.n_fired, board.n_none, board.n_checked);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
